FILE: hdl/arm_pkg.sv
// shared widths, opcodes, status codes and types of the address region map
package arm_pkg;

    localparam int ADDR_W         = 16;
    localparam int OPCODE_W       = 2;
    localparam int KIND_W         = 3;
    localparam int STATUS_W       = 2;
    localparam int MAX_RANGES_DEF = 16;
    localparam int KIND_BITS_DEF  = 3;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_SET      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLASSIFY = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // piece slots emitted per old entry during a set, in emit order
    localparam int SLOT_NEW_BEFORE = 0;
    localparam int SLOT_OLD_LEFT   = 1;
    localparam int SLOT_NEW_INSIDE = 2;
    localparam int SLOT_OLD_RIGHT  = 3;
    localparam int SLOT_N          = 4;

    typedef struct packed {
        logic [SLOT_N-1:0] load_mask;
        logic [SLOT_N-1:0] pick;
        logic              use_new;
        logic [ADDR_W-1:0] piece_start;
        logic [ADDR_W-1:0] piece_end;
    } t_cut;

endpackage

FILE: hdl/arm_if.sv
// request and result channel interfaces of the address region map
interface arm_req_if
    import arm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   range_start;
    logic [ADDR_W-1:0]   range_end;
    logic [KIND_W-1:0]   region_kind;
    logic [ADDR_W-1:0]   query_address;

    modport source (
        output valid, opcode, range_start, range_end, region_kind, query_address,
        input  ready
    );
    modport sink (
        input  valid, opcode, range_start, range_end, region_kind, query_address,
        output ready
    );
endinterface

interface arm_rsp_if
    import arm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   found_kind;
    logic                hit;

    modport source (
        output valid, status, found_kind, hit,
        input  ready
    );
    modport sink (
        input  valid, status, found_kind, hit,
        output ready
    );
endinterface

FILE: hdl/arm_ram.sv
// generic single write port ram with registered read
module arm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/arm_cut.sv
// overlap compare unit: splits one stored range against the new range
module arm_cut
    import arm_pkg::*;
(
    input  logic [ADDR_W-1:0] i_ent_start,
    input  logic [ADDR_W-1:0] i_ent_end,
    input  logic [ADDR_W-1:0] i_start,
    input  logic [ADDR_W-1:0] i_end,
    input  logic              i_placed,
    input  logic [SLOT_N-1:0] i_mask,
    output t_cut              o_cut
);
    logic              overlap;
    logic              new_before;
    logic [SLOT_N-1:0] pick;

    assign overlap    = !((i_ent_end < i_start) || (i_ent_start > i_end));
    assign new_before = !i_placed && (i_ent_start > i_start);

    always_comb begin
        o_cut.load_mask                  = '0;
        o_cut.load_mask[SLOT_NEW_BEFORE] = new_before;
        o_cut.load_mask[SLOT_OLD_LEFT]   = overlap ? (i_ent_start < i_start) : 1'b1;
        o_cut.load_mask[SLOT_NEW_INSIDE] = overlap && (i_ent_end > i_end)
                                           && !(i_placed || new_before);
        o_cut.load_mask[SLOT_OLD_RIGHT]  = overlap && (i_ent_end > i_end);
    end

    // lowest pending slot goes out first
    assign pick       = i_mask & (~i_mask + SLOT_N'(1));
    assign o_cut.pick = pick;

    always_comb begin
        o_cut.use_new     = 1'b0;
        o_cut.piece_start = i_ent_start;
        o_cut.piece_end   = i_ent_end;
        if (pick[SLOT_NEW_BEFORE] || pick[SLOT_NEW_INSIDE]) begin
            o_cut.use_new     = 1'b1;
            o_cut.piece_start = i_start;
            o_cut.piece_end   = i_end;
        end else if (pick[SLOT_OLD_LEFT]) begin
            // untouched entry, or its part below the new range
            o_cut.piece_end = overlap ? (i_start - ADDR_W'(1)) : i_ent_end;
        end else if (pick[SLOT_OLD_RIGHT]) begin
            o_cut.piece_start = i_end + ADDR_W'(1);
        end
    end
endmodule

FILE: hdl/address_region_map_core.sv
// top level of the address region map: sequencer, table banks and result register
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------------
//  i_req   | in  | valid / ready | opcode, range_start, range_end, region_kind,
//          |     |               | query_address
//  o_rsp   | out | valid / ready | status, found_kind, hit
//
// one request at a time; i_req.ready is high only while the sequencer is idle
// remove and classify visit each stored entry in turn (classify stops at first hit);
//   set also visits each entry, with one more push per extra piece from a trim or split;
//   entries are read through the single ram read port, walked one entry per visit
// reset clears the entry count, the bank select and the result valid flag; table
//   contents are never cleared, only entries below the count are read
// a finished result waits in the sequencer until the output register is free
module address_region_map_core
    import arm_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int KIND_BITS  = KIND_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    arm_req_if.sink   i_req,
    arm_rsp_if.source o_rsp
);
    localparam int IW = $clog2(MAX_RANGES);       // entry index
    localparam int CW = $clog2(MAX_RANGES + 1);   // entry count
    localparam int NW = $clog2(MAX_RANGES + 3);   // rebuilt count, may overshoot by two
    localparam int AW = IW + 1;                   // bank bit plus index
    localparam int EW = 2 * ADDR_W + KIND_BITS;   // one stored entry

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic                 r_bank, n_bank;       // which half of the ram holds the table
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_idx, n_idx;         // entry being visited
    logic [NW-1:0]        r_n, n_n;             // entries written into the spare bank
    logic                 r_placed, n_placed;   // new range already emitted
    logic                 r_removed, n_removed; // remove key already skipped
    logic [SLOT_N-1:0]    r_mask, n_mask;       // pieces still pending for this entry
    logic [OPCODE_W-1:0]  r_op, n_op;
    logic [ADDR_W-1:0]    r_s, n_s;
    logic [ADDR_W-1:0]    r_e, n_e;
    logic [KIND_BITS-1:0] r_k, n_k;
    logic [ADDR_W-1:0]    r_a, n_a;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [KIND_BITS-1:0] r_kind, n_kind;
    logic                 r_hit, n_hit;
    logic                 r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [KIND_W-1:0]    r_out_kind, n_out_kind;
    logic                 r_out_hit, n_out_hit;

    logic                 ram_we;
    logic [EW-1:0]        ram_wdata;
    logic [EW-1:0]        ram_rdata;
    logic [ADDR_W-1:0]    ent_start;
    logic [ADDR_W-1:0]    ent_end;
    logic [KIND_BITS-1:0] ent_kind;
    t_cut                 cut;
    logic                 last_ent;
    logic [2:0]           adv_state;
    logic [IW-1:0]        adv_idx;
    logic [NW-1:0]        n_total;
    logic                 wr_ok;
    logic [SLOT_N-1:0]    mask_left;
    logic                 req_fire;
    logic                 rsp_fire;

    // both banks in one ram: the table is read from r_bank, rebuilt into the other
    arm_ram #(
        .WIDTH (EW),
        .DEPTH (2 ** AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({~r_bank, r_n[IW-1:0]}),
        .i_wdata (ram_wdata),
        .i_raddr ({r_bank, r_idx}),
        .o_rdata (ram_rdata)
    );

    assign ent_start = ram_rdata[EW-1 -: ADDR_W];
    assign ent_end   = ram_rdata[EW-ADDR_W-1 -: ADDR_W];
    assign ent_kind  = ram_rdata[KIND_BITS-1:0];

    arm_cut u_cut (
        .i_ent_start (ent_start),
        .i_ent_end   (ent_end),
        .i_start     (r_s),
        .i_end       (r_e),
        .i_placed    (r_placed),
        .i_mask      (r_mask),
        .o_cut       (cut)
    );

    assign req_fire    = i_req.valid && i_req.ready;
    assign rsp_fire    = r_out_valid && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign last_ent  = (CW'(r_idx) + CW'(1) == r_count);
    assign adv_state = last_ent ? S_FINAL : S_READ;
    assign adv_idx   = last_ent ? r_idx : r_idx + IW'(1);
    assign n_total   = r_n + NW'(!r_placed);
    assign wr_ok     = (r_n < NW'(MAX_RANGES));
    assign mask_left = r_mask & ~cut.pick;

    always_comb begin
        n_state     = r_state;
        n_bank      = r_bank;
        n_count     = r_count;
        n_idx       = r_idx;
        n_n         = r_n;
        n_placed    = r_placed;
        n_removed   = r_removed;
        n_mask      = r_mask;
        n_op        = r_op;
        n_s         = r_s;
        n_e         = r_e;
        n_k         = r_k;
        n_a         = r_a;
        n_status    = r_status;
        n_kind      = r_kind;
        n_hit       = r_hit;
        ram_we      = 1'b0;
        ram_wdata   = {cut.piece_start, cut.piece_end, cut.use_new ? r_k : ent_kind};

        n_out_valid  = r_out_valid && !rsp_fire;
        n_out_status = r_out_status;
        n_out_kind   = r_out_kind;
        n_out_hit    = r_out_hit;

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_op      = i_req.opcode;
                    n_s       = i_req.range_start;
                    n_e       = i_req.range_end;
                    n_k       = KIND_BITS'(i_req.region_kind);
                    n_a       = i_req.query_address;
                    n_idx     = '0;
                    n_n       = '0;
                    n_placed  = 1'b0;
                    n_removed = 1'b0;
                    n_status  = ST_OK;
                    n_kind    = '0;
                    n_hit     = 1'b0;
                    if (i_req.opcode == OP_NONE) begin
                        n_state = S_DONE;
                    end else if (i_req.opcode == OP_SET
                                 && i_req.range_start > i_req.range_end) begin
                        n_status = ST_ORDER;
                        n_state  = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_FINAL;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                // ram read of the current entry is in flight
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (r_op == OP_SET) begin
                    n_mask   = cut.load_mask;
                    n_placed = r_placed || cut.load_mask[SLOT_NEW_BEFORE]
                               || cut.load_mask[SLOT_NEW_INSIDE];
                    n_state  = S_PUSH;
                end else if (r_op == OP_REMOVE) begin
                    if (!r_removed && ent_start == r_s) begin
                        n_removed = 1'b1;
                    end else begin
                        ram_we    = wr_ok;
                        ram_wdata = ram_rdata;
                        n_n       = r_n + NW'(1);
                    end
                    n_state = adv_state;
                    n_idx   = adv_idx;
                end else begin
                    // classify: first containing entry wins
                    if (r_a >= ent_start && r_a <= ent_end) begin
                        n_status = ST_OK;
                        n_kind   = ent_kind;
                        n_hit    = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_state = adv_state;
                        n_idx   = adv_idx;
                    end
                end
            end
            S_PUSH: begin
                if (r_mask == '0) begin
                    // entry fully covered by the new range
                    n_state = adv_state;
                    n_idx   = adv_idx;
                end else begin
                    ram_we = wr_ok;
                    n_n    = r_n + NW'(1);
                    n_mask = mask_left;
                    if (mask_left == '0) begin
                        n_state = adv_state;
                        n_idx   = adv_idx;
                    end
                end
            end
            S_FINAL: begin
                n_state = S_DONE;
                if (r_op == OP_SET) begin
                    // new range goes last when nothing started above it
                    if (!r_placed) begin
                        ram_we    = wr_ok;
                        ram_wdata = {r_s, r_e, r_k};
                    end
                    if (n_total > NW'(MAX_RANGES)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_bank  = ~r_bank;
                        n_count = CW'(n_total);
                    end
                end else if (r_op == OP_REMOVE) begin
                    if (r_removed) begin
                        n_bank  = ~r_bank;
                        n_count = CW'(r_n);
                    end else begin
                        n_status = ST_MISS;
                    end
                end else begin
                    n_status = ST_MISS;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_kind   = KIND_W'(r_kind);
                    n_out_hit    = r_hit;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bank      <= n_bank;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_n          <= n_n;
        r_placed     <= n_placed;
        r_removed    <= n_removed;
        r_mask       <= n_mask;
        r_op         <= n_op;
        r_s          <= n_s;
        r_e          <= n_e;
        r_k          <= n_k;
        r_a          <= n_a;
        r_status     <= n_status;
        r_kind       <= n_kind;
        r_hit        <= n_hit;
        r_out_status <= n_out_status;
        r_out_kind   <= n_out_kind;
        r_out_hit    <= n_out_hit;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.found_kind = r_out_kind;
    assign o_rsp.hit        = r_out_hit;

`ifndef SYNTHESIS
    // table never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("entry count above capacity");

    // the table only changes as a request finishes
    a_count_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |-> r_state == S_DONE)
        else $error("entry count changed outside commit");

    // an accepted request always takes the sequencer out of idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> r_state != S_IDLE)
        else $error("sequencer idle after accepting a request");
`endif

endmodule
